@@ rtl/dtd_pkg.sv @@
// Package for the deadline transmit decider: sequencer states and fixed-point constants.
// Used by deadline_transmit_decider_core; has no dependencies of its own.
`default_nettype none

package dtd_pkg;

    localparam int FRAC_BITS = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AVG_GO,
        S_AVG_WAIT,
        S_SLOT,
        S_WALK,
        S_SLOT_END,
        S_REC_CHK,
        S_REC_RD,
        S_REC_MUL,
        S_REC_WAIT,
        S_DECIDE,
        S_EXP,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

@@ rtl/dtd_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; instantiated once by deadline_transmit_decider_core and shared by all divides.
`default_nettype none

module dtd_div #(
    parameter int N = 40
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [N-1:0] i_num,
    input  wire logic [N-1:0] i_den,
    output logic              o_done,
    output logic [N-1:0]      o_quo
);

    localparam int CNTW = $clog2(N + 1);

    logic [N-1:0]    r_rem, n_rem;
    logic [N-1:0]    r_quo, n_quo;
    logic [N-1:0]    r_den;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [N:0]      shifted;
    logic [N:0]      diff;

    always_comb begin
        shifted = {r_rem, r_quo[N-1]};
        diff    = shifted - {1'b0, r_den};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_num;
            n_cnt  = CNTW'(N);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[N]) begin
                n_rem = diff[N-1:0];
                n_quo = {r_quo[N-2:0], 1'b1};
            end else begin
                n_rem = shifted[N-1:0];
                n_quo = {r_quo[N-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

@@ rtl/deadline_transmit_decider_core.sv @@
// Deadline transmit decider. One node's queued deadlines arrive as items; the item
// marked last starts the decision and, once finished, exactly one result item leaves.
// While a decision runs the input channel is stalled. A decision first takes the mean
// with the divider (skipped when the queue is empty), then makes SLOTS slot passes that
// walk the entries from the epoch on (slots below it skip the walk), then up to SLOTS-2
// recursion steps of one divide each, and finally counts the expired entries when
// transmitting; N is the width of the shared serial divider, one quotient bit per cycle
// (35 at the default sizes), which sets the recursion time, while the single-port
// deadline memory sets the reward time. Other items are taken without stalling.
// Depends on dtd_pkg and dtd_div.
`default_nettype none

module deadline_transmit_decider_core
    import dtd_pkg::*;
#(
    parameter int SLOTS       = 32,
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [5:0] i_deadline,
    input  wire logic       i_entry_valid,
    input  wire logic       i_has_head,
    input  wire logic [4:0] i_epoch,
    input  wire logic       i_last,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_transmit,
    output logic [4:0]      o_best_slot,
    output logic [6:0]      o_expired_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SW = CW + 7;
    localparam int IW = $clog2(SLOTS);
    localparam int EW = ((IW > 5) ? IW : 5) + 1;
    localparam int RW = $clog2(QUEUE_DEPTH + SLOTS) + 8;
    localparam int FW = RW + FRAC_BITS - 1;
    localparam int DN = FW + IW;
    localparam int DW = IW + 8;
    localparam int XW = (CW > 7) ? CW : 7;

    t_state r_state, n_state;

    logic        [CW-1:0] r_count, n_count;
    logic signed [SW-1:0] r_sum, n_sum;
    logic signed [RW-1:0] r_avg, n_avg;
    logic signed [RW-1:0] r_t, n_t;
    logic signed [RW-1:0] r_acc, n_acc;
    logic signed [RW-1:0] r_best_r, n_best_r;
    logic        [IW-1:0] r_i, n_i;
    logic        [IW-1:0] r_best, n_best;
    logic        [IW-1:0] r_idx, n_idx;
    logic        [CW-1:0] r_e, n_e;
    logic                 r_pend, n_pend;
    logic        [FW-1:0] r_rn, n_rn;
    logic        [FW-1:0] r_rb, n_rb;
    logic        [DN-1:0] r_prod, n_prod;
    logic                 r_tx, n_tx;
    logic        [XW-1:0] r_xcnt, n_xcnt;
    logic        [4:0]    r_epoch, n_epoch;

    // Deadline store and slot reward store.
    logic signed [6:0]    mem_dl [QUEUE_DEPTH];
    logic signed [RW-1:0] mem_rw [SLOTS];
    logic signed [6:0]    r_dl_rd;
    logic signed [RW-1:0] r_rw_rd;
    logic                 dl_we;
    logic        [AW-1:0] dl_addr;
    logic signed [6:0]    dl_wdata;
    logic                 rw_we;

    logic                 div_start;
    logic        [DN-1:0] div_num;
    logic        [DN-1:0] div_den;
    logic                 div_done;
    logic        [DN-1:0] div_quo;

    logic        [SW-1:0] sum_mag;
    logic signed [RW-1:0] quo_avg;
    logic signed [DW-1:0] diff;
    logic        [EW-1:0] i_ext, best_ext, epoch_ext;
    logic        [FW-1:0] quo_f;
    logic        [FW-1:0] rv;
    logic        [FW-1:0] best_fx;
    logic [IW+FW-1:0]     mul;

    dtd_div #(.N(DN)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        sum_mag   = (r_sum < 0) ? SW'(-r_sum) : SW'(r_sum);
        quo_avg   = RW'(div_quo);
        diff      = DW'(r_dl_rd) - $signed(DW'(r_i));
        i_ext     = EW'(r_i);
        best_ext  = EW'(r_best);
        epoch_ext = EW'(r_epoch);
        quo_f     = FW'(div_quo);
        rv        = (r_rw_rd > 0) ? {r_rw_rd[RW-2:0], {FRAC_BITS{1'b0}}} : '0;
        best_fx   = {r_best_r[RW-2:0], {FRAC_BITS{1'b0}}};
        mul       = r_idx * r_rn;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_sum     = r_sum;
        n_avg     = r_avg;
        n_t       = r_t;
        n_acc     = r_acc;
        n_best_r  = r_best_r;
        n_i       = r_i;
        n_best    = r_best;
        n_idx     = r_idx;
        n_e       = r_e;
        n_pend    = 1'b0;
        n_rn      = r_rn;
        n_rb      = r_rb;
        n_prod    = r_prod;
        n_tx      = r_tx;
        n_xcnt    = r_xcnt;
        n_epoch   = r_epoch;
        dl_we     = 1'b0;
        dl_addr   = r_e[AW-1:0];
        dl_wdata  = $signed({1'b0, i_deadline}) - $signed({6'b0, i_has_head});
        rw_we     = 1'b0;
        div_start = 1'b0;
        div_num   = DN'(sum_mag);
        div_den   = DN'(r_count);

        unique case (r_state)
            S_IDLE: begin
                dl_addr = r_count[AW-1:0];
                if (i_valid) begin
                    if (i_entry_valid && (r_count < CW'(QUEUE_DEPTH))) begin
                        dl_we   = 1'b1;
                        n_count = r_count + 1'b1;
                        n_sum   = r_sum + SW'(dl_wdata);
                    end
                    if (i_last) begin
                        n_epoch = i_epoch;
                        n_state = S_AVG_GO;
                    end
                end
            end
            S_AVG_GO: begin
                n_i      = '0;
                n_t      = '0;
                n_best   = '0;
                n_best_r = '1;
                if (r_count == '0) begin
                    n_avg   = '0;
                    n_state = S_SLOT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_AVG_WAIT;
                end
            end
            S_AVG_WAIT: begin
                if (div_done) begin
                    n_avg   = (r_sum < 0) ? -quo_avg : quo_avg;
                    n_state = S_SLOT;
                end
            end
            S_SLOT: begin
                n_e = '0;
                if (i_ext >= epoch_ext) begin
                    n_acc   = r_t;
                    n_state = S_WALK;
                end else begin
                    n_acc   = '0;
                    n_state = S_SLOT_END;
                end
            end
            S_WALK: begin
                // Each read is issued in the cycle before its accumulate.
                if (r_e < r_count) begin
                    n_e    = r_e + 1'b1;
                    n_pend = 1'b1;
                end
                if (r_pend && (diff > 0)) begin
                    n_acc = r_acc + RW'(diff);
                end
                if ((r_e == r_count) && !r_pend) begin
                    n_state = S_SLOT_END;
                end
            end
            S_SLOT_END: begin
                rw_we = 1'b1;
                if (r_acc > r_best_r) begin
                    n_best_r = r_acc;
                    n_best   = r_i;
                end
                if (r_i != '0) begin
                    n_t = r_t + r_avg - $signed(RW'(r_i)) + RW'(1);
                end
                if (r_i == IW'(SLOTS - 1)) begin
                    n_idx   = IW'(SLOTS - 2);
                    n_rb    = FW'(1) << FRAC_BITS;
                    n_rn    = '0;
                    n_state = S_REC_CHK;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SLOT;
                end
            end
            S_REC_CHK: begin
                n_state = (r_idx > r_best) ? S_REC_RD : S_DECIDE;
            end
            S_REC_RD: begin
                n_prod  = DN'(mul);
                n_state = S_REC_MUL;
            end
            S_REC_MUL: begin
                div_start = 1'b1;
                div_num   = r_prod + DN'(r_rb);
                div_den   = DN'(r_idx) + 1'b1;
                n_state   = S_REC_WAIT;
            end
            S_REC_WAIT: begin
                div_num = r_prod + DN'(r_rb);
                div_den = DN'(r_idx) + 1'b1;
                if (div_done) begin
                    n_rn    = quo_f;
                    n_rb    = (rv > quo_f) ? rv : quo_f;
                    n_idx   = r_idx - 1'b1;
                    n_state = S_REC_CHK;
                end
            end
            S_DECIDE: begin
                n_e    = '0;
                n_xcnt = '0;
                n_tx   = (r_best <= IW'(SLOTS - 2)) && (epoch_ext == best_ext)
                         && (best_fx >= r_rb);
                n_state = (n_tx) ? S_EXP : S_OUT;
            end
            S_EXP: begin
                if (r_e < r_count) begin
                    n_e    = r_e + 1'b1;
                    n_pend = 1'b1;
                end
                if (r_pend && (DW'(r_dl_rd) < $signed(DW'(r_epoch)))) begin
                    n_xcnt = r_xcnt + 1'b1;
                end
                if ((r_e == r_count) && !r_pend) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_count = '0;
                    n_sum   = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_sum   <= '0;
            r_pend  <= 1'b0;
            r_tx    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_pend  <= n_pend;
            r_tx    <= n_tx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_avg    <= n_avg;
        r_t      <= n_t;
        r_acc    <= n_acc;
        r_best_r <= n_best_r;
        r_i      <= n_i;
        r_best   <= n_best;
        r_idx    <= n_idx;
        r_e      <= n_e;
        r_rn     <= n_rn;
        r_rb     <= n_rb;
        r_prod   <= n_prod;
        r_xcnt   <= n_xcnt;
        r_epoch  <= n_epoch;
    end

    always_ff @(posedge i_clk) begin
        if (dl_we) begin
            mem_dl[dl_addr] <= dl_wdata;
        end
        r_dl_rd <= mem_dl[dl_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rw_we) begin
            mem_rw[r_i] <= r_acc;
        end
        if (r_state == S_REC_RD) begin
            r_rw_rd <= mem_rw[r_idx];
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_transmit      = r_tx;
    assign o_best_slot     = best_ext[4:0];
    assign o_expired_count = r_tx ? r_xcnt[6:0] : 7'd0;

endmodule

`default_nettype wire

@@ dv/deadline_transmit_decider_core_tb.sv @@
// Self-checking testbench for deadline_transmit_decider_core: directed, overflow, random
// and backpressure tests against a behavioral predictor of the transmit/wait decision.
// Depends on the RTL (dtd_pkg, dtd_div, deadline_transmit_decider_core) only.
`timescale 1ns / 100ps

module deadline_transmit_decider_core_tb;

    localparam int SLOTS     = 32;
    localparam int QDEPTH    = 64;
    localparam int WD_LIMIT  = 40000;

    typedef struct {
        bit       transmit;
        bit [4:0] best_slot;
        bit [6:0] expired_count;
    } decision_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [5:0] i_deadline = '0;
    logic       i_entry_valid = 1'b0;
    logic       i_has_head = 1'b0;
    logic [4:0] i_epoch = '0;
    logic       i_last = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_transmit;
    logic [4:0] o_best_slot;
    logic [6:0] o_expired_count;

    deadline_transmit_decider_core dut (.*);

    always #10 i_clk = ~i_clk;

    // Model of the node queue as the block should hold it.
    int        queued_dl[QDEPTH];
    int        queued_cnt = 0;
    int        queued_sum = 0;
    decision_t pending_decisions[$];
    int        fail_count = 0;
    int        idle_cycles = 0;
    int        rx_hold = 0;

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Decision for the current queue plus an optional entry carried by the last item.
    function automatic decision_t predict_decision(input int ep, input bit add, input int d);
        int                 q[QDEPTH];
        int                 n;
        int                 s;
        longint             avg;
        longint             rew[SLOTS];
        longint             best_r;
        longint             t;
        int                 best;
        longint unsigned    rb;
        longint unsigned    rn;
        longint unsigned    nrn;
        longint unsigned    rv;
        decision_t          res;
        q = queued_dl;
        n = queued_cnt;
        s = queued_sum;
        if (add && n < QDEPTH) begin
            q[n] = d;
            n++;
            s += d;
        end
        avg = (n != 0) ? longint'(s / n) : 0;
        best = 0;
        best_r = -1;
        for (int i = 0; i < SLOTS; i++) begin
            rew[i] = 0;
            if (i >= ep) begin
                for (int e = 0; e < n; e++) begin
                    t = longint'(q[e]) - i;
                    if (t > 0) rew[i] += t;
                end
                for (int j = 0; j < i - 1; j++) rew[i] += avg - j;
            end
            if (rew[i] > best_r) begin
                best_r = rew[i];
                best = i;
            end
        end
        res.transmit = 1'b0;
        res.best_slot = best[4:0];
        res.expired_count = '0;
        if (best <= SLOTS - 2) begin
            rb = 64'd1 << 16;
            rn = 0;
            for (int k = SLOTS - 1; k > best + 1; k--) begin
                nrn = (longint'(k - 1) * rn + rb) / longint'(k);
                rv = (rew[k-1] > 0) ? (longint'(rew[k-1]) << 16) : 0;
                rn = nrn;
                rb = (rv > rn) ? rv : rn;
            end
            if (ep == best && best_r >= 0 && (longint'(best_r) << 16) >= rb)
                res.transmit = 1'b1;
        end
        if (res.transmit) begin
            int cnt;
            cnt = 0;
            for (int e = 0; e < n; e++)
                if (q[e] < ep) cnt++;
            res.expired_count = cnt[6:0];
        end
        return res;
    endfunction

    // Sends one item; called and returns at a falling edge, valid left high.
    task automatic send_item(input int dl, input bit ev, input bit hd, input int ep,
                             input bit lst);
        int g;
        int adj;
        g = gap_len();
        if (g > 0) begin
            i_valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_deadline = dl[5:0];
        i_entry_valid = ev;
        i_has_head = hd;
        i_epoch = ep[4:0];
        i_last = lst;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        adj = dl - (hd ? 1 : 0);
        if (lst) pending_decisions.push_back(predict_decision(ep, ev, adj));
        if (ev && queued_cnt < QDEPTH) begin
            queued_dl[queued_cnt] = adj;
            queued_cnt++;
            queued_sum += adj;
        end
        if (lst) begin
            queued_cnt = 0;
            queued_sum = 0;
        end
        @(negedge i_clk);
    endtask

    task automatic pause_sender();
        i_valid = 1'b0;
        @(negedge i_clk);
    endtask

    // One node: n entries, the last item carries an entry when entry_on_last is set.
    // With aim_tx the epoch is picked, where one exists, so that the block transmits.
    task automatic send_node(input int n, input bit hd, input bit entry_on_last,
                             input bit aim_tx);
        int ep;
        int dl_last;
        int hits[$];
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) send_item($urandom_range(63), 1'b0, hd,
                                                   $urandom_range(31), 1'b0);
            send_item($urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(32),
                      1'b1, hd, $urandom_range(31), 1'b0);
        end
        dl_last = $urandom_range(63);
        ep = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(8);
        if (aim_tx) begin
            for (int e = 0; e < SLOTS; e++)
                if (predict_decision(e, entry_on_last, dl_last - (hd ? 1 : 0)).transmit)
                    hits.push_back(e);
            if (hits.size() > 0) ep = hits[$urandom_range(hits.size() - 1)];
        end
        send_item(dl_last, entry_on_last, hd, ep, 1'b1);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (pending_decisions.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed();
        // Empty queue at the first, the next-to-last and the last slot.
        send_item(0, 1'b0, 1'b0, 0, 1'b1);
        send_item(0, 1'b0, 1'b0, SLOTS - 2, 1'b1);
        send_item(0, 1'b0, 1'b0, SLOTS - 1, 1'b1);
        // A zero deadline with a head is stored as minus one and always expires.
        send_item(0, 1'b1, 1'b1, 0, 1'b0);
        send_item(63, 1'b1, 1'b1, 5, 1'b0);
        send_item(20, 1'b1, 1'b1, 3, 1'b1);
        // Largest deadlines, entry on the last item, last slot.
        send_item(63, 1'b1, 1'b0, 0, 1'b0);
        send_item(63, 1'b1, 1'b0, SLOTS - 1, 1'b1);
        send_item(32, 1'b1, 1'b0, 31, 1'b1);
        send_node(3, 1'b0, 1'b1, 1'b1);
        send_node(4, 1'b1, 1'b0, 1'b1);
        send_node(2, 1'b0, 1'b1, 1'b0);
        wait_drained();
    endtask

    task automatic test_queue_overflow();
        send_node(QDEPTH + 6, 1'b0, 1'b1, 1'b1);
        send_node(QDEPTH - 1, 1'b1, 1'b1, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_nodes();
        for (int k = 0; k < 25; k++)
            send_node($urandom_range(7), $urandom_range(1), $urandom_range(1),
                      $urandom_range(1));
        // Stray items that carry no entry, closed by a last item.
        for (int k = 0; k < 6; k++)
            send_item($urandom_range(63), 1'b0, $urandom_range(1), $urandom_range(31),
                      1'b0);
        send_item($urandom_range(63), 1'b0, 1'b0, $urandom_range(31), 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        rx_hold = 5000;
        for (int k = 0; k < 4; k++) send_node($urandom_range(1, 3), 1'b0, 1'b1, 1'b1);
        pause_sender();
        wait_drained();
    endtask

    // Receiver side: random stalls, and a long counted hold-off on request.
    initial begin
        @(negedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                i_stall = 1'b1;
                repeat (rx_hold) @(negedge i_clk);
                rx_hold = 0;
            end
            i_stall = ($urandom_range(9) < 3);
            if (i_stall && $urandom_range(9) == 0) repeat ($urandom_range(10, 60))
                @(negedge i_clk);
            else
                @(negedge i_clk);
        end
    end

    // Result checking and the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
            if (o_valid && !i_stall) begin
                if (pending_decisions.size() == 0) begin
                    $error("result with no decision pending");
                    fail_count++;
                end else begin
                    decision_t exp_d;
                    exp_d = pending_decisions.pop_front();
                    if (o_transmit !== exp_d.transmit) begin
                        $error("transmit: expected %0d, got %0d", exp_d.transmit,
                               o_transmit);
                        fail_count++;
                    end
                    if (o_best_slot !== exp_d.best_slot) begin
                        $error("best_slot: expected %0d, got %0d", exp_d.best_slot,
                               o_best_slot);
                        fail_count++;
                    end
                    if (o_expired_count !== exp_d.expired_count) begin
                        $error("expired_count: expected %0d, got %0d",
                               exp_d.expired_count, o_expired_count);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_queue_overflow();
        test_backpressure();
        test_random_nodes();
        test_backpressure();
        wait_drained();
        repeat (200) @(negedge i_clk);
        if (fail_count == 0 && pending_decisions.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
